[sv/ipv4_subnet_classifier_unit_macros.svh]
// ---------------------------------------------------------------------------
// ipv4_subnet_classifier_unit_macros.svh
// Assertion helper macros for the subnet classifier.
// ---------------------------------------------------------------------------
`ifndef IPV4_SUBNET_CLASSIFIER_UNIT_MACROS_SVH
`define IPV4_SUBNET_CLASSIFIER_UNIT_MACROS_SVH

// Same-cycle implication, off while reset is high
`define SC_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: implication");

// Next-cycle implication, off while reset is high
`define SC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

[sv/ipv4sc_pkg.sv]
// ---------------------------------------------------------------------------
// ipv4sc_pkg
// Shared types, codes and helpers for the IPv4 subnet classifier.
// ---------------------------------------------------------------------------
package ipv4sc_pkg;

  // Default number of slots per table
  localparam int DEFAULT_TABLE_DEPTH = 16;

  // Request codes
  localparam logic [1:0] REQ_LOOKUP      = 2'd0;
  localparam logic [1:0] REQ_WR_INTERNAL = 2'd1;
  localparam logic [1:0] REQ_WR_SPECIAL  = 2'd2;
  localparam logic [1:0] REQ_WR_POLICY   = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] CFG_INTERNAL_COUNT = 2'd0;
  localparam logic [1:0] CFG_SPECIAL_COUNT  = 2'd1;
  localparam logic [1:0] CFG_POLICY_COUNT   = 2'd2;

  localparam int CNT_W = 5;
  // Wide enough for any slot, count or depth up to 256
  localparam int CMP_W = 9;

  // Loopback network 127/8
  localparam logic [7:0] LOOPBACK_NET = 8'd127;

  // Sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_FINISH
  } state_t;

  // Table write enables
  typedef struct packed {
    logic int_we;
    logic spc_we;
    logic pol_we;
  } tbl_we_t;

  // One slot read from each table
  typedef struct packed {
    logic [31:0] int_addr;
    logic [31:0] int_mask;
    logic [31:0] spc_addr;
    logic [31:0] spc_mask;
    logic [7:0]  spc_kind;
    logic [31:0] pol_addr;
  } tbl_rd_t;

  // Masked subnet compare
  function automatic logic masked_hit(input logic [31:0] a, input logic [31:0] m,
                                      input logic [31:0] e);
    return (a & m) == e;
  endfunction

endpackage

[sv/ipv4_subnet_classifier_unit.sv]
// ---------------------------------------------------------------------------
// ipv4_subnet_classifier_unit
// Classifies an IPv4 address against internal, special and policy tables.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one request per transaction:
//   a lookup of query_addr, or a write of one slot of one table.
//   Output channel (out_valid/out_ready) returns one result per request.
//   Config port (cfg_we/cfg_index/cfg_data) sets the three table counts;
//   write it only while no request is outstanding.
//   Lookup: the slots are scanned one per cycle through a single read port
//   on each table, then the sequencer passes S_DRAIN and S_FINISH and the
//   result is loaded into the output register as the block returns to idle.
//   Table write: the sequencer goes straight to S_FINISH, which loads the result.
//   One request at a time.
//   A finished result sits in an output register; while the receiver stalls
//   the block still accepts and scans the next request, then holds it until
//   the output register frees up.
//   Reset clears the counts (an empty internal table marks every address as
//   internal) and the control state; table contents are undefined until
//   written.
// ---------------------------------------------------------------------------
`include "ipv4_subnet_classifier_unit_macros.svh"

module ipv4_subnet_classifier_unit #(
  parameter int TABLE_DEPTH = ipv4sc_pkg::DEFAULT_TABLE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  // config
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [4:0]  cfg_data,
  // requests
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  req_type,
  input  logic [31:0] query_addr,
  input  logic [3:0]  entry_slot,
  input  logic [31:0] entry_addr,
  input  logic [31:0] entry_mask,
  input  logic [7:0]  entry_kind,
  // results
  output logic        out_valid,
  input  logic        out_ready,
  output logic        is_internal,
  output logic [7:0]  addr_type,
  output logic        is_policy,
  output logic        write_done
);
  import ipv4sc_pkg::*;

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

  state_t           state, state_next;
  logic [IDX_W-1:0] idx, idx_next;
  logic [IDX_W-1:0] rd_idx;
  logic             rd_vld;

  logic [CNT_W-1:0] internal_count, special_count, policy_count;

  logic [31:0]      qaddr;
  logic             is_wr;
  logic             acc_int, acc_spc_found, acc_pol;
  logic [7:0]       acc_kind;

  tbl_we_t          we;
  tbl_rd_t          rd_data;
  logic             in_acc, slot_ok, load_out;
  logic             int_ok, spc_ok, pol_ok;

  assign in_acc  = in_valid && in_ready;
  assign slot_ok = CMP_W'(entry_slot) < CMP_W'(TABLE_DEPTH);

  // Config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      internal_count <= '0;
      special_count  <= '0;
      policy_count   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_INTERNAL_COUNT: internal_count <= cfg_data;
        CFG_SPECIAL_COUNT:  special_count  <= cfg_data;
        CFG_POLICY_COUNT:   policy_count   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Tables
  ipv4sc_tables #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .IDX_W      (IDX_W)
  ) u_tables (
    .clk       (clk),
    .we        (we),
    .wr_addr   (IDX_W'(entry_slot)),
    .entry_addr(entry_addr),
    .entry_mask(entry_mask),
    .entry_kind(entry_kind),
    .rd_addr   (idx),
    .rd_data   (rd_data)
  );

  // Sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      idx    <= '0;
      rd_vld <= 1'b0;
    end else begin
      state  <= state_next;
      idx    <= idx_next;
      rd_vld <= (state == S_SCAN);
    end
  end

  // Next state, table writes, output load
  always_comb begin
    state_next = state;
    idx_next   = idx;
    in_ready   = 1'b0;
    load_out   = 1'b0;
    we         = '0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (req_type == REQ_LOOKUP) begin
            idx_next   = '0;
            state_next = S_SCAN;
          end else begin
            we.int_we  = slot_ok && (req_type == REQ_WR_INTERNAL);
            we.spc_we  = slot_ok && (req_type == REQ_WR_SPECIAL);
            we.pol_we  = slot_ok && (req_type == REQ_WR_POLICY);
            state_next = S_FINISH;
          end
        end
      end
      S_SCAN: begin
        idx_next = idx + IDX_W'(1);
        if (idx == LAST_IDX) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (!out_valid || out_ready) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Slot is below each table's count (slot < depth, so no clamp needed)
  assign int_ok = CMP_W'(rd_idx) < CMP_W'(internal_count);
  assign spc_ok = CMP_W'(rd_idx) < CMP_W'(special_count);
  assign pol_ok = CMP_W'(rd_idx) < CMP_W'(policy_count);

  // Scan accumulators
  always_ff @(posedge clk) begin
    rd_idx <= idx;
    if (in_acc) begin
      qaddr         <= query_addr;
      is_wr         <= (req_type != REQ_LOOKUP);
      acc_int       <= (internal_count == '0) || (query_addr[31:24] == LOOPBACK_NET);
      acc_spc_found <= 1'b0;
      acc_kind      <= '0;
      acc_pol       <= 1'b0;
    end else if (rd_vld) begin
      if (int_ok && masked_hit(qaddr, rd_data.int_mask, rd_data.int_addr)) begin
        acc_int <= 1'b1;
      end
      // first hit in slot order wins
      if (!acc_spc_found && spc_ok &&
          masked_hit(qaddr, rd_data.spc_mask, rd_data.spc_addr)) begin
        acc_spc_found <= 1'b1;
        acc_kind      <= rd_data.spc_kind;
      end
      if (pol_ok && (qaddr == rd_data.pol_addr)) begin
        acc_pol <= 1'b1;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      is_internal <= !is_wr && acc_int;
      addr_type   <= is_wr ? 8'd0 : acc_kind;
      is_policy   <= !is_wr && acc_pol;
      write_done  <= is_wr;
    end
  end

  // Assertions
  `SC_ASSERT_IMPLIES(a_wr_result_clean, clk, rst, out_valid && write_done, !is_internal && addr_type == 8'd0 && !is_policy)
  `SC_ASSERT_NEXT(a_lookup_starts_scan, clk, rst, in_valid && in_ready && req_type == REQ_LOOKUP, state == S_SCAN && idx == '0)
  `SC_ASSERT_IMPLIES(a_drain_has_data, clk, rst, state == S_DRAIN, rd_vld)
  `SC_ASSERT_IMPLIES(a_idle_no_scan, clk, rst, in_ready, !rd_vld)

endmodule

[sv/ipv4sc_tables.sv]
// ---------------------------------------------------------------------------
// ipv4sc_tables
// Internal, special and policy tables; one write port, one registered read.
// ---------------------------------------------------------------------------
module ipv4sc_tables #(
  parameter int TABLE_DEPTH = ipv4sc_pkg::DEFAULT_TABLE_DEPTH,
  parameter int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
  input  logic                clk,
  input  ipv4sc_pkg::tbl_we_t we,
  input  logic [IDX_W-1:0]    wr_addr,
  input  logic [31:0]         entry_addr,
  input  logic [31:0]         entry_mask,
  input  logic [7:0]          entry_kind,
  input  logic [IDX_W-1:0]    rd_addr,
  output ipv4sc_pkg::tbl_rd_t rd_data
);
  import ipv4sc_pkg::*;

  logic [63:0] int_mem [TABLE_DEPTH];
  logic [71:0] spc_mem [TABLE_DEPTH];
  logic [31:0] pol_mem [TABLE_DEPTH];

  // Writes
  always_ff @(posedge clk) begin
    if (we.int_we) begin
      int_mem[wr_addr] <= {entry_addr, entry_mask};
    end
    if (we.spc_we) begin
      spc_mem[wr_addr] <= {entry_addr, entry_mask, entry_kind};
    end
    if (we.pol_we) begin
      pol_mem[wr_addr] <= entry_addr;
    end
  end

  // Registered reads, all tables at the same slot
  always_ff @(posedge clk) begin
    {rd_data.int_addr, rd_data.int_mask} <= int_mem[rd_addr];
    {rd_data.spc_addr, rd_data.spc_mask, rd_data.spc_kind} <= spc_mem[rd_addr];
    rd_data.pol_addr <= pol_mem[rd_addr];
  end

endmodule
